// ===== rtl/pool2d_pkg.sv =====
// ----------------------------------------------------------------------------
// pool2d_pkg
// shared widths, defaults and register codes of the 2-d pooling block
// ----------------------------------------------------------------------------
package pool2d_pkg;

    localparam int DEF_MAX_DIM      = 256;
    localparam int DEF_MAX_WINDOW   = 4;
    localparam int DEF_MAX_CHANNELS = 1024;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_SIZE     = 3'd1,
        REG_STRIDE   = 3'd2,
        REG_CHANNELS = 3'd3,
        REG_HEIGHT   = 3'd4,
        REG_WIDTH    = 3'd5
    } cfg_reg_t;

    // pooling kinds
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

endpackage

// ===== rtl/pool2d_linebuf.sv =====
// ----------------------------------------------------------------------------
// pool2d_linebuf
// line store: one row slot per window row, one write and one registered read
// ----------------------------------------------------------------------------
module pool2d_linebuf
    import pool2d_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0]        wr_slot,
    input  logic [$clog2(MAX_DIM)-1:0]           wr_col,
    input  logic signed [SAMPLE_W-1:0]           wr_data,
    input  logic [$clog2(MAX_WINDOW)-1:0]        rd_slot,
    input  logic [$clog2(MAX_DIM)-1:0]           rd_col,
    output logic signed [SAMPLE_W-1:0]           rd_data
);

    logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW][MAX_DIM];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot][wr_col] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_slot][rd_col];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pool2d_divider.sv =====
// ----------------------------------------------------------------------------
// pool2d_divider
// radix-2 restoring divide of the window sum by size squared, toward zero
// ----------------------------------------------------------------------------
module pool2d_divider
    import pool2d_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic signed [SAMPLE_W+2*$clog2(MAX_WINDOW)-1:0]   dividend,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]                   side,
    output logic                                              done,
    output logic signed [SAMPLE_W-1:0]                        quotient
);

    localparam int SW  = SAMPLE_W + 2 * $clog2(MAX_WINDOW);
    localparam int SZW = $clog2(MAX_WINDOW + 1);
    localparam int DW  = 2 * SZW;
    localparam int CW  = $clog2(SW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DW-1:0]     div_reg;
    logic [DW-1:0]     rem_reg;
    logic [SW-1:0]     quo_reg;
    logic [DW:0]       trial;
    logic              fits;
    logic [SW-1:0]     mag;
    logic [SW-1:0]     signed_q;

    assign trial    = {rem_reg, quo_reg[SW-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign mag      = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
    assign signed_q = neg_reg ? SW'(-quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(SW);
                rem_reg  <= '0;
                quo_reg  <= mag;
                neg_reg  <= dividend[SW-1];
                div_reg  <= DW'(side) * DW'(side);
            end
            else if (busy_reg)
            begin
                // one quotient bit per cycle
                rem_reg  <= fits ? DW'(trial - {1'b0, div_reg}) : DW'(trial);
                quo_reg  <= {quo_reg[SW-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = signed_q[SAMPLE_W-1:0];

endmodule

// ===== rtl/pooling_2d_max_average.sv =====
// ----------------------------------------------------------------------------
// pooling_2d_max_average
// streaming 2-d max / average pooling over a channel-major feature volume
// ----------------------------------------------------------------------------
// Samples come one beat at a time, all rows of channel 0 in raster order,
// then channel 1 and so on. Each sample is written into a line store of
// MAX_WINDOW row slots. A sample that completes a window (valid placement,
// stride steps, no padding) starts a sequencer that reads the window back
// through the single store read port, one sample per cycle, and folds it
// into a running maximum and sum with one shared compare/add unit. Average
// mode then runs a one-bit-per-cycle restoring divider by size squared.
// The sequencer may also wait for the output register to drain. in_ready
// is low while a window is in work. The result sits in an output register
// so a new sample is taken while the previous result waits. Any
// configuration write to a known register restarts the volume; the line
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pooling_2d_max_average
    import pool2d_pkg::*;
#(
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  pooled_value,
    output logic                        volume_end
);

    localparam int SLW = $clog2(MAX_WINDOW);
    localparam int SZW = $clog2(MAX_WINDOW + 1);
    localparam int PW  = $clog2(MAX_DIM);
    localparam int KW  = PW + 3;
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW  = SAMPLE_W + 2 * SLW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_FINISH,
        ST_DIV,
        ST_OUT
    } state_t;

    // configuration registers
    logic              mode_reg;
    logic [2:0]        size_reg;
    logic [2:0]        stride_reg;
    logic [10:0]       chan_cfg_reg;
    logic [8:0]        height_reg;
    logic [8:0]        width_reg;

    // effective (clamped) configuration
    logic [SZW-1:0]    s_eff;
    logic [2:0]        st_eff;
    logic [CHW-1:0]    ch_last;
    logic [PW-1:0]     h_last;
    logic [PW-1:0]     w_last;
    int                s_i;
    int                ch_i;
    int                h_i;
    int                w_i;
    int                slot_i;

    // stream position
    logic [PW-1:0]     col_reg;
    logic [PW-1:0]     row_reg;
    logic [CHW-1:0]    chan_reg;
    logic [SLW-1:0]    slot_reg;
    logic [KW-1:0]     ckey_reg;
    logic [KW-1:0]     rkey_reg;

    // sequencer
    state_t            state_reg;
    logic [SLW-1:0]    rd_slot_reg;
    logic [PW-1:0]     c0_reg;
    logic [SLW-1:0]    i_reg;
    logic [SLW-1:0]    j_reg;
    logic              rd_pend_reg;
    logic              first_reg;
    logic              end_reg;
    logic signed [SAMPLE_W-1:0] best_reg;
    logic signed [SW-1:0]       sum_reg;
    logic signed [SAMPLE_W-1:0] res_reg;

    // output register
    logic              out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic              out_end_reg;

    logic              in_beat;
    logic              cfg_known;
    logic              col_hit;
    logic              row_hit;
    logic              hit;
    logic              is_end;
    logic [SLW-1:0]    start_slot;
    logic [PW-1:0]     start_col;
    logic [SLW-1:0]    slot_inc;
    logic [SLW-1:0]    rd_slot_inc;
    logic              last_i;
    logic              last_j;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic signed [SAMPLE_W-1:0] div_q;
    logic signed [SAMPLE_W-1:0] rd_data;

    // ---- clamp configuration ----
    always_comb
    begin
        if (size_reg == 3'd0)
            s_i = 1;
        else if (int'(size_reg) > MAX_WINDOW)
            s_i = MAX_WINDOW;
        else
            s_i = int'(size_reg);

        if (chan_cfg_reg == 11'd0)
            ch_i = 1;
        else if (int'(chan_cfg_reg) > MAX_CHANNELS)
            ch_i = MAX_CHANNELS;
        else
            ch_i = int'(chan_cfg_reg);

        if (height_reg == 9'd0)
            h_i = 1;
        else if (int'(height_reg) > MAX_DIM)
            h_i = MAX_DIM;
        else
            h_i = int'(height_reg);

        if (width_reg == 9'd0)
            w_i = 1;
        else if (int'(width_reg) > MAX_DIM)
            w_i = MAX_DIM;
        else
            w_i = int'(width_reg);

        // slot of the top window row: (slot - (s-1)) mod MAX_WINDOW
        slot_i = int'(slot_reg) + MAX_WINDOW - (s_i - 1);
        if (slot_i >= MAX_WINDOW)
            slot_i = slot_i - MAX_WINDOW;
    end

    assign s_eff      = SZW'(s_i);
    assign st_eff     = (stride_reg == 3'd0) ? 3'd1 : stride_reg;
    assign ch_last    = CHW'(ch_i - 1);
    assign h_last     = PW'(h_i - 1);
    assign w_last     = PW'(w_i - 1);
    assign start_slot = SLW'(slot_i);
    assign start_col  = PW'(col_reg - PW'(s_i - 1));

    // ---- window completion ----
    // key registers hold the origin of the next window along each axis
    assign col_hit = (KW'(col_reg) == ckey_reg + KW'(s_eff) - KW'(1));
    assign row_hit = (KW'(row_reg) == rkey_reg + KW'(s_eff) - KW'(1));
    assign hit     = col_hit && row_hit;
    // last window of the volume: no further window fits in either direction
    assign is_end  = (chan_reg == ch_last)
                     && (KW'(row_reg) + KW'(st_eff) > KW'(h_last))
                     && (KW'(col_reg) + KW'(st_eff) > KW'(w_last));

    assign slot_inc    = (slot_reg == SLW'(MAX_WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    assign rd_slot_inc = (rd_slot_reg == SLW'(MAX_WINDOW - 1)) ? '0 : rd_slot_reg + 1'b1;
    assign last_j      = (SZW'(j_reg) == s_eff - SZW'(1));
    assign last_i      = (SZW'(i_reg) == s_eff - SZW'(1));

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign div_start = (state_reg == ST_FINISH) && (mode_reg == MODE_AVG);

    always_comb
    begin
        unique case (cfg_reg_t'(cfg_index))
            REG_MODE, REG_SIZE, REG_STRIDE,
            REG_CHANNELS, REG_HEIGHT, REG_WIDTH: cfg_known = 1'b1;
            default:                             cfg_known = 1'b0;
        endcase
    end

    pool2d_linebuf #(
        .MAX_DIM    (MAX_DIM),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_linebuf (
        .clk     (clk),
        .wr_en   (in_beat),
        .wr_slot (slot_reg),
        .wr_col  (col_reg),
        .wr_data (sample),
        .rd_slot (rd_slot_reg),
        .rd_col  (PW'(c0_reg + PW'(j_reg))),
        .rd_data (rd_data)
    );

    pool2d_divider #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .side     (s_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_MAX;
            size_reg      <= 3'd2;
            stride_reg    <= 3'd2;
            chan_cfg_reg  <= 11'd1;
            height_reg    <= 9'd8;
            width_reg     <= 9'd8;
            col_reg       <= '0;
            row_reg       <= '0;
            chan_reg      <= '0;
            slot_reg      <= '0;
            ckey_reg      <= '0;
            rkey_reg      <= '0;
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // ---- configuration: known register restarts the volume ----
            if (cfg_write && cfg_known)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MODE:     mode_reg     <= cfg_data[0];
                    REG_SIZE:     size_reg     <= cfg_data[2:0];
                    REG_STRIDE:   stride_reg   <= cfg_data[2:0];
                    REG_CHANNELS: chan_cfg_reg <= cfg_data[10:0];
                    REG_HEIGHT:   height_reg   <= cfg_data[8:0];
                    REG_WIDTH:    width_reg    <= cfg_data[8:0];
                    default:      mode_reg     <= mode_reg;
                endcase
                col_reg  <= '0;
                row_reg  <= '0;
                chan_reg <= '0;
                slot_reg <= '0;
                ckey_reg <= '0;
                rkey_reg <= '0;
            end
            else if (in_beat)
            begin
                // ---- advance the stream position ----
                if (col_reg == w_last)
                begin
                    col_reg  <= '0;
                    ckey_reg <= '0;
                    if (row_reg == h_last)
                    begin
                        row_reg  <= '0;
                        rkey_reg <= '0;
                        slot_reg <= '0;
                        chan_reg <= (chan_reg == ch_last) ? '0 : chan_reg + 1'b1;
                    end
                    else
                    begin
                        row_reg  <= row_reg + 1'b1;
                        slot_reg <= slot_inc;
                        if (row_hit)
                            rkey_reg <= rkey_reg + KW'(st_eff);
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                    if (col_hit)
                        ckey_reg <= ckey_reg + KW'(st_eff);
                end
            end

            // ---- shared compare/add unit ----
            rd_pend_reg <= (state_reg == ST_READ);
            if (rd_pend_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg)
                begin
                    best_reg <= rd_data;
                    sum_reg  <= SW'(rd_data);
                end
                else
                begin
                    if (rd_data > best_reg)
                        best_reg <= rd_data;
                    sum_reg <= sum_reg + SW'(rd_data);
                end
            end

            // ---- output register ----
            // a beat taken while the next result loads is handled in ST_OUT
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            // ---- sequencer ----
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat && hit)
                    begin
                        state_reg   <= ST_READ;
                        rd_slot_reg <= start_slot;
                        c0_reg      <= start_col;
                        i_reg       <= '0;
                        j_reg       <= '0;
                        first_reg   <= 1'b1;
                        end_reg     <= is_end;
                    end
                end
                ST_READ:
                begin
                    // one window sample per cycle through the read port
                    if (last_j)
                    begin
                        j_reg       <= '0;
                        i_reg       <= i_reg + 1'b1;
                        rd_slot_reg <= rd_slot_inc;
                        if (last_i)
                            state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (mode_reg == MODE_AVG)
                        state_reg <= ST_DIV;
                    else
                    begin
                        res_reg   <= best_reg;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= div_q;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // result moves to the output only once the last beat is gone
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= res_reg;
                        out_end_reg   <= end_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign pooled_value = out_value_reg;
    assign volume_end   = out_end_reg;

`ifndef SYNTHESIS
    // a waiting result beat holds its payload until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg
            && $stable(out_value_reg) && $stable(out_end_reg))
        else $error("pending result beat overwritten");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide wait");

    // window read counters stay inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (SZW'(i_reg) < s_eff) && (SZW'(j_reg) < s_eff))
        else $error("window read index out of range");

    // a window read always leads to the drain cycle with data in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> rd_pend_reg)
        else $error("drain without pending read data");
`endif

endmodule

// ===== dv/pooling_2d_max_average_tb.sv =====
// ----------------------------------------------------------------------------
// pooling_2d_max_average_tb
// self-checking bench for the streaming 2-d max / average pooling block
// ----------------------------------------------------------------------------
// Streams feature volumes through the block under many register settings.
// A scoreboard keeps its own line store and position counters, predicts a
// pooled value for every window that a sample completes, and compares each
// output beat in order. Both channels idle at random; some phases run flat out.
// ----------------------------------------------------------------------------
module pooling_2d_max_average_tb;
    import pool2d_pkg::*;

    localparam int STORE_ROWS  = DEF_MAX_WINDOW;
    localparam int STORE_COLS  = DEF_MAX_DIM;
    localparam int DRAIN_WAIT  = 80;        // longer than one average-mode window
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1550;

    // ------------------------------------------------------------------
    // scoreboard: window predictor plus queue of pooled values in flight
    // ------------------------------------------------------------------
    class pool_scoreboard;
        typedef struct packed {
            logic signed [SAMPLE_W-1:0] value;
            logic                       last;
        } pooled_t;

        logic                       avg_mode;
        logic [2:0]                 size_reg;
        logic [2:0]                 stride_reg;
        logic [10:0]                chan_reg;
        logic [8:0]                 height_reg;
        logic [8:0]                 width_reg;
        logic signed [SAMPLE_W-1:0] line_rows [STORE_ROWS][STORE_COLS];
        int                         col_pos;
        int                         row_pos;
        int                         chan_pos;
        pooled_t                    pending [$];
        int                         errors;
        int                         results;

        function new();
            avg_mode   = MODE_MAX;
            size_reg   = 3'd2;
            stride_reg = 3'd2;
            chan_reg   = 11'd1;
            height_reg = 9'd8;
            width_reg  = 9'd8;
            col_pos    = 0;
            row_pos    = 0;
            chan_pos   = 0;
            errors     = 0;
            results    = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_MODE:     avg_mode   = data[0];
                REG_SIZE:     size_reg   = data[2:0];
                REG_STRIDE:   stride_reg = data[2:0];
                REG_CHANNELS: chan_reg   = data[10:0];
                REG_HEIGHT:   height_reg = data[8:0];
                REG_WIDTH:    width_reg  = data[8:0];
                default:      return;
            endcase
            // any write to a known register restarts the volume, line store kept
            col_pos  = 0;
            row_pos  = 0;
            chan_pos = 0;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x);
            int side, step, chans, rows, cols;
            int top, left, best, sum, last_r, last_c;
            logic signed [SAMPLE_W-1:0] v;
            pooled_t exp_beat;
            side  = (size_reg == 0) ? 1 : (size_reg > STORE_ROWS) ? STORE_ROWS : size_reg;
            step  = (stride_reg == 0) ? 1 : stride_reg;
            chans = (chan_reg == 0) ? 1 : (chan_reg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS
                                                                         : chan_reg;
            rows  = (height_reg == 0) ? 1 : (height_reg > STORE_COLS) ? STORE_COLS : height_reg;
            cols  = (width_reg == 0) ? 1 : (width_reg > STORE_COLS) ? STORE_COLS : width_reg;
            line_rows[row_pos % STORE_ROWS][col_pos] = x;
            if (row_pos + 1 >= side && col_pos + 1 >= side &&
                (row_pos + 1 - side) % step == 0 && (col_pos + 1 - side) % step == 0)
            begin
                top  = row_pos + 1 - side;
                left = col_pos + 1 - side;
                best = line_rows[top % STORE_ROWS][left];
                sum  = 0;
                for (int i = 0; i < side; i++)
                begin
                    for (int j = 0; j < side; j++)
                    begin
                        v = line_rows[(top + i) % STORE_ROWS][left + j];
                        if (v > best)
                            best = v;
                        sum += v;
                    end
                end
                last_r = ((rows - side) / step) * step + side - 1;
                last_c = ((cols - side) / step) * step + side - 1;
                exp_beat.value = (avg_mode == MODE_AVG) ? SAMPLE_W'(sum / (side * side))
                                                        : SAMPLE_W'(best);
                exp_beat.last  = (chan_pos == chans - 1) && (row_pos == last_r) &&
                                 (col_pos == last_c);
                pending.push_back(exp_beat);
            end
            col_pos++;
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= rows)
                begin
                    row_pos = 0;
                    chan_pos++;
                    if (chan_pos >= chans)
                        chan_pos = 0;
                end
            end
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] value, logic last);
            pooled_t exp_beat;
            results++;
            if (pending.size() == 0)
            begin
                $error("unexpected output beat: pooled_value %0d volume_end %0b", value, last);
                errors++;
                return;
            end
            exp_beat = pending.pop_front();
            if (value !== exp_beat.value)
            begin
                $error("pooled_value: expected %0d actual %0d", exp_beat.value, value);
                errors++;
            end
            if (last !== exp_beat.last)
            begin
                $error("volume_end: expected %0b actual %0b", exp_beat.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [SAMPLE_W-1:0]  pooled_value;
    logic                        volume_end;

    pool_scoreboard pool_sb;
    int  cycle_count;
    int  sent_items;
    int  phase_count;
    bit  flat_out;          // phase with no idling on either side

    pooling_2d_max_average DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pooled_value (pooled_value),
        .volume_end   (volume_end)
    );

    // 12-unit clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // every output beat goes to the scoreboard; values read here are pre-edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            pool_sb.check_result(pooled_value, volume_end);
    end

    // receiver: random stall before each beat, none in flat-out phases
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = flat_out ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // write all six registers in one burst, write enable held high
    task automatic program_regs(input logic [CFG_W-1:0] mode_v, size_v, stride_v,
                                input logic [CFG_W-1:0] chan_v, height_v, width_v);
        logic [CFG_W-1:0] vals [6];
        cfg_reg_t idx;
        vals = '{mode_v, size_v, stride_v, chan_v, height_v, width_v};
        cfg_write <= 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            idx = cfg_reg_t'(i);
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge clk);
            pool_sb.write_reg(idx, vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    // one input beat after a random gap; valid stays high across back-to-back beats
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        gap = flat_out ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= x;
        do @(posedge clk); while (!in_ready);
        pool_sb.note_sample(x);
        sent_items++;
    endtask

    // block goes idle: all results back, then margin for a window still in work
    task automatic settle();
        in_valid <= 1'b0;
        while (pool_sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int chans, rows, cols, count, sz;
        logic signed [SAMPLE_W-1:0] corner [4];
        pool_sb     = new();
        cycle_count = 0;
        sent_items  = 0;
        phase_count = 0;
        flat_out    = 1'b0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        sample      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // average of overlapping 2x2 windows on a 3x3 plane, full-scale values
        program_regs(MODE_AVG, 2, 1, 1, 3, 3);
        corner = '{16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000};
        for (int i = 0; i < 9; i++)
            push_sample(corner[i % 4]);
        settle();
        // zero size, stride and dimensions fall back to one
        program_regs(MODE_MAX, 0, 0, 0, 0, 0);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        settle();
        // oversized window clamps to four, plane too small: no output at all
        program_regs(MODE_MAX, 7, 1, 1, 3, 3);
        for (int i = 0; i < 9; i++)
            push_sample(draw_sample());
        settle();
        phase_count = 3;

        // ---------------- random phases ----------------
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            flat_out = ($urandom_range(0, 4) == 0);
            sz = $urandom_range(0, 7);
            case (phase_count % 9)
                4:       begin chans = 1;    rows = 2;   cols = 511; sz = 2; end // width saturates
                6:       begin chans = 1;    rows = 300; cols = 1;   sz = 1; end // height saturates
                8:       begin chans = 2047; rows = 1;   cols = 1;   sz = 1; end // channel limit
                default:
                begin
                    chans = $urandom_range(0, 3);
                    rows  = $urandom_range(0, 10);
                    cols  = $urandom_range(0, 10);
                end
            endcase
            // each extreme phase once, so the run stays short
            if (phase_count >= 9 && (phase_count % 9) inside {4, 6, 8})
            begin
                chans = 2;
                rows  = 6;
                cols  = 7;
            end
            program_regs(CFG_W'($urandom_range(0, 1)), CFG_W'(sz),
                         CFG_W'($urandom_range(0, 7)), CFG_W'(chans),
                         CFG_W'(rows), CFG_W'(cols));
            // mostly a whole volume, sometimes cut short or wrapping into the next one
            count = ((chans == 0) ? 1 : (chans > 1024) ? 1024 : chans) *
                    ((rows == 0) ? 1 : (rows > 256) ? 256 : rows) *
                    ((cols == 0) ? 1 : (cols > 256) ? 256 : cols);
            case ($urandom_range(0, 5))
                0:       count = $urandom_range(1, count);
                1:       count = count + $urandom_range(1, count);
                default: ;
            endcase
            for (int i = 0; i < count; i++)
                push_sample(draw_sample());
            settle();
            phase_count++;
        end

        $display("covered %0d register settings, %0d random samples after the directed set",
                 phase_count, sent_items);
        $display("%0d pooled beats checked, %0d mismatches", pool_sb.results, pool_sb.errors);
        if (pool_sb.errors == 0 && pool_sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
